// ===== rtl/core/dhc_pkg.sv =====
`timescale 1ns / 1ps
// Package for the dehumidifier hysteresis controller: field widths, register
// indexes, configuration record, sequencer states and control records.
// No dependencies.
package dhc_pkg;

  localparam int HUM_W      = 10;
  localparam int TEMP_W     = 12;
  localparam int TOD_W      = 17;
  localparam int TGT_T_W    = 9;
  localparam int MINOFF_W   = 17;
  localparam int FAN_W      = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;

  localparam int AVG_WINDOW_DEF = 16;

  // Demand sets 5.0 % above target; the permit clears 1.0 C below target.
  localparam int HUM_MARGIN = 50;
  localparam int TEMP_BAND  = 10;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HUM_SETPOINT    = 3'd0,
    REG_TEMP_SETPOINT   = 3'd1,
    REG_MIN_OFF_SECONDS = 3'd2,
    REG_FAN_SPEED_ON    = 3'd3,
    REG_FAN_SPEED_OFF   = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic [HUM_W-1:0]    hum_setpoint;
    logic [TGT_T_W-1:0]  temp_setpoint;
    logic [MINOFF_W-1:0] min_off_seconds;
    logic [FAN_W-1:0]    fan_speed_on;
    logic [FAN_W-1:0]    fan_speed_off;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    hum_setpoint:    10'd550,
    temp_setpoint:   9'd200,
    min_off_seconds: 17'd300,
    fan_speed_on:    8'd255,
    fan_speed_off:   8'd0
  };

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_MUL,
    ST_DECIDE
  } dhc_state_e;

  // Commands from the sequencer to the datapath.
  typedef struct packed {
    logic load;
    logic rd_en;
    logic update;
    logic mul;
    logic decide;
  } dhc_cmd_t;

  // Status from the datapath to the sequencer.
  typedef struct packed {
    logic slot_free;
  } dhc_stat_t;

endpackage

// ===== rtl/core/dhc_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces for samples, results and register writes.
// Depends on dhc_pkg.
interface dhc_sample_if;
  logic                                valid;
  logic                                ready;
  logic [dhc_pkg::HUM_W-1:0]           humidity_sample;
  logic signed [dhc_pkg::TEMP_W-1:0]   temperature_sample;
  logic [dhc_pkg::TOD_W-1:0]           time_of_day;

  modport source (output valid, humidity_sample, temperature_sample, time_of_day,
                  input ready);
  modport sink (input valid, humidity_sample, temperature_sample, time_of_day,
                output ready);
endinterface

interface dhc_result_if;
  logic                      valid;
  logic                      ready;
  logic                      dehumidifier_on;
  logic [dhc_pkg::FAN_W-1:0] backwall_fan_speed;
  logic                      demand_active;
  logic                      override_active;

  modport source (output valid, dehumidifier_on, backwall_fan_speed, demand_active,
                  override_active, input ready);
  modport sink (input valid, dehumidifier_on, backwall_fan_speed, demand_active,
                override_active, output ready);
endinterface

interface dhc_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [dhc_pkg::CFG_IDX_W-1:0]  reg_index;
  logic [dhc_pkg::CFG_DATA_W-1:0] wr_data;

  modport source (output valid, reg_index, wr_data, input ready);
  modport sink (input valid, reg_index, wr_data, output ready);
endinterface

// ===== rtl/core/dhc_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module dhc_ram #(
  parameter int Width = 10,
  parameter int Depth = 16,
  parameter int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/dhc_ctrl.sv =====
`timescale 1ns / 1ps
// Sequencer for one sample: read, update, multiply, decide.
// Depends on dhc_pkg.
module dhc_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  dhc_pkg::dhc_stat_t stat_i,
  output dhc_pkg::dhc_cmd_t  cmd_o
);
  import dhc_pkg::*;

  dhc_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_UPDATE;
      end
      ST_UPDATE: state_d = ST_MUL;
      ST_MUL:    state_d = ST_DECIDE;
      ST_DECIDE: begin
        if (stat_i.slot_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.rd_en  = 1'b1;
        cmd_o.load   = in_valid_i;
      end
      ST_UPDATE: cmd_o.update = 1'b1;
      ST_MUL:    cmd_o.mul    = 1'b1;
      ST_DECIDE: cmd_o.decide = stat_i.slot_free;
      default: begin
      end
    endcase
  end

endmodule

// ===== rtl/core/dhc_datapath.sv =====
`timescale 1ns / 1ps
// Datapath: configuration registers, moving average with its ring RAM,
// hysteresis flags, drive timing and the result register. Depends on dhc_pkg, dhc_ram.
module dhc_datapath #(
  parameter int AVG_WINDOW = dhc_pkg::AVG_WINDOW_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  dhc_pkg::dhc_cmd_t                 cmd_i,
  output dhc_pkg::dhc_stat_t                stat_o,
  input  logic [dhc_pkg::HUM_W-1:0]         hum_i,
  input  logic signed [dhc_pkg::TEMP_W-1:0] temp_i,
  input  logic [dhc_pkg::TOD_W-1:0]         tod_i,
  input  logic                              cfg_we_i,
  input  logic [dhc_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [dhc_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  logic                              res_ready_i,
  output logic                              res_valid_o,
  output logic                              res_on_o,
  output logic [dhc_pkg::FAN_W-1:0]         res_fan_o,
  output logic                              res_demand_o,
  output logic                              res_override_o
);
  import dhc_pkg::*;

  localparam int CntW  = $clog2(AVG_WINDOW + 1);
  localparam int PtrW  = (AVG_WINDOW > 1) ? $clog2(AVG_WINDOW) : 1;
  localparam int SumW  = HUM_W + CntW;
  localparam int TempX = TEMP_W + 1;

  cfg_t cfg_q;

  logic [HUM_W-1:0]         hum_q;
  logic signed [TEMP_W-1:0] temp_q;
  logic [TOD_W-1:0]         tod_q;

  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [SumW-1:0]  sum_q, sum_d;
  logic [PtrW-1:0]  ptr_q, ptr_d;
  logic             dem_q, dem_d;
  logic             ovr_q, ovr_d;
  logic             drv_q, drv_d;
  logic [TOD_W-1:0] last_q, last_d;
  logic [SumW-1:0]  prod_q;

  logic             res_valid_q;
  logic             res_on_q;
  logic [FAN_W-1:0] res_fan_q;
  logic             res_dem_q;
  logic             res_ovr_q;

  logic [HUM_W-1:0]        old_sample;
  logic                    full;
  logic signed [TempX-1:0] temp_ext, tgt_ext, limit_lo;
  logic                    hum_over;
  logic                    off_done;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_HUM_SETPOINT:    cfg_q.hum_setpoint    <= cfg_data_i[HUM_W-1:0];
        REG_TEMP_SETPOINT:   cfg_q.temp_setpoint   <= cfg_data_i[TGT_T_W-1:0];
        REG_MIN_OFF_SECONDS: cfg_q.min_off_seconds <= cfg_data_i[MINOFF_W-1:0];
        REG_FAN_SPEED_ON:    cfg_q.fan_speed_on    <= cfg_data_i[FAN_W-1:0];
        REG_FAN_SPEED_OFF:   cfg_q.fan_speed_off   <= cfg_data_i[FAN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      hum_q  <= hum_i;
      temp_q <= temp_i;
      tod_q  <= tod_i;
    end
  end

  dhc_ram #(
    .Width (HUM_W),
    .Depth (AVG_WINDOW),
    .AddrW (PtrW)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (cmd_i.update),
    .waddr_i (ptr_q),
    .wdata_i (hum_q),
    .re_i    (cmd_i.rd_en),
    .raddr_i (ptr_q),
    .rdata_o (old_sample)
  );

  assign full     = (cnt_q == CntW'(AVG_WINDOW));
  assign temp_ext = {temp_q[TEMP_W-1], temp_q};
  assign tgt_ext  = $signed({{(TempX - TGT_T_W){1'b0}}, cfg_q.temp_setpoint});
  assign limit_lo = tgt_ext - $signed(TempX'(TEMP_BAND));
  assign hum_over = {1'b0, hum_q} >
                    ({1'b0, cfg_q.hum_setpoint} + (HUM_W + 1)'(HUM_MARGIN));
  // A time before the last switch-off means midnight has passed.
  assign off_done = (tod_q < last_q) ||
                    ((tod_q - last_q) > TOD_W'(cfg_q.min_off_seconds));

  always_comb begin
    cnt_d  = cnt_q;
    sum_d  = sum_q;
    ptr_d  = ptr_q;
    ovr_d  = ovr_q;
    dem_d  = dem_q;
    drv_d  = drv_q;
    last_d = last_q;
    if (cmd_i.update) begin
      sum_d = sum_q - (full ? SumW'(old_sample) : '0) + SumW'(hum_q);
      if (!full) cnt_d = cnt_q + 1'b1;
      ptr_d = (ptr_q == PtrW'(AVG_WINDOW - 1)) ? '0 : ptr_q + 1'b1;
      if (temp_ext < limit_lo) ovr_d = 1'b0;
      if (temp_ext > tgt_ext)  ovr_d = 1'b1;
    end
    if (cmd_i.decide) begin
      if (dem_q) begin
        if ((cnt_q != '0) && (sum_q < prod_q)) dem_d = 1'b0;
      end else if (hum_over) begin
        dem_d = 1'b1;
        cnt_d = '0;
        sum_d = '0;
        ptr_d = '0;
      end
      if (dem_d && ovr_q) begin
        if (off_done) drv_d = 1'b1;
      end else begin
        if (drv_q) last_d = tod_q;
        drv_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      sum_q  <= '0;
      ptr_q  <= '0;
      dem_q  <= 1'b0;
      ovr_q  <= 1'b1;
      drv_q  <= 1'b0;
      last_q <= '0;
    end else begin
      cnt_q  <= cnt_d;
      sum_q  <= sum_d;
      ptr_q  <= ptr_d;
      dem_q  <= dem_d;
      ovr_q  <= ovr_d;
      drv_q  <= drv_d;
      last_q <= last_d;
    end
  end

  // Target times count, the exact form of "average below target".
  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      prod_q <= SumW'(cfg_q.hum_setpoint) * SumW'(cnt_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (cmd_i.decide) begin
      res_valid_q <= 1'b1;
    end else if (res_ready_i) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.decide) begin
      res_on_q  <= drv_d;
      res_fan_q <= drv_d ? cfg_q.fan_speed_on : cfg_q.fan_speed_off;
      res_dem_q <= dem_d;
      res_ovr_q <= ovr_q;
    end
  end

  assign stat_o.slot_free = !res_valid_q || res_ready_i;
  assign res_valid_o      = res_valid_q;
  assign res_on_o         = res_on_q;
  assign res_fan_o        = res_fan_q;
  assign res_demand_o     = res_dem_q;
  assign res_override_o   = res_ovr_q;

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(AVG_WINDOW))
    else $error("average count above window");

  a_ptr_tracks_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !full |-> (CntW'(ptr_q) == cnt_q))
    else $error("ring pointer out of step with count");

  a_decide_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.decide |=> res_valid_q)
    else $error("result not registered after decision");

  a_on_needs_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && res_on_q) |-> (res_dem_q && res_ovr_q))
    else $error("drive on without demand and permit");
`endif

endmodule

// ===== rtl/core/dehumidifier_hysteresis_controller_unit.sv =====
`timescale 1ns / 1ps
// Top level of the dehumidifier hysteresis controller: sequencer and datapath.
// Depends on dhc_pkg, dhc_if, dhc_ctrl, dhc_datapath and dhc_ram.
// The result is registered by the decision step, which follows the update and
// multiply steps of the input transaction. A new sample is taken only after the
// ring read, sum update, target-times-count multiply and decision of the last.
// A waiting result blocks only the decision step of the next sample.
// Reset (asynchronous, active low) restores register defaults, sets the permit and
// clears average, demand and drive; the sample ring is not cleared, nor need be.
module dehumidifier_hysteresis_controller_unit #(
  parameter int AVG_WINDOW = dhc_pkg::AVG_WINDOW_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  dhc_sample_if.sink   sample_i,
  dhc_result_if.source result_o,
  dhc_cfg_if.sink      cfg_i
);
  import dhc_pkg::*;

  dhc_cmd_t  cmd;
  dhc_stat_t stat;

  // Register writes are taken in any cycle; the user must make them only while idle, as the block does not enforce it.
  assign cfg_i.ready = 1'b1;

  // The sequencer accepts a sample transaction only from its idle step.
  dhc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (sample_i.valid),
    .in_ready_o (sample_i.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // The datapath holds the data state, the ring RAM and the result register,
  // so a finished result waits for the sink while the next sample is taken in.
  dhc_datapath #(
    .AVG_WINDOW (AVG_WINDOW)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .hum_i          (sample_i.humidity_sample),
    .temp_i         (sample_i.temperature_sample),
    .tod_i          (sample_i.time_of_day),
    .cfg_we_i       (cfg_i.valid),
    .cfg_idx_i      (cfg_i.reg_index),
    .cfg_data_i     (cfg_i.wr_data),
    .res_ready_i    (result_o.ready),
    .res_valid_o    (result_o.valid),
    .res_on_o       (result_o.dehumidifier_on),
    .res_fan_o      (result_o.backwall_fan_speed),
    .res_demand_o   (result_o.demand_active),
    .res_override_o (result_o.override_active)
  );

endmodule
